>>> sv/crlm_pkg.sv
`default_nettype none
package crlm_pkg;

  localparam int unsigned NumEntries = 256;
  localparam int unsigned IdxW       = 8;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned NumChan    = 4;
  localparam int unsigned CfgW       = 3;
  localparam int unsigned EntryW     = NumChan * ChanW;

  localparam logic [CfgW-1:0]   ChanRgba   = 3'd4;
  localparam logic [EntryW-1:0] EntryWhite = 32'hFFFF_FFFF;
  localparam logic [EntryW-1:0] EntryBlack = 32'h0000_00FF;
  localparam logic [EntryW-1:0] EntryMask  = 32'hFFFF_FF00;

  typedef enum logic [1:0] {
    CMD_RESET   = 2'd0,
    CMD_SET_KEY = 2'd1,
    CMD_BUILD   = 2'd2,
    CMD_PIXEL   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RA_PIXEL = 2'd0,
    RA_KEY   = 2'd1,
    RA_SCAN  = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    pix_load;
    logic    key_load;
    logic    key_write;
    logic    tbl_reset;
    logic    scan_clear;
    logic    scan_inc;
    logic    hi_load;
    logic    div_step;
    logic    fill_step;
    logic    prev_load;
    logic    prev_from_hi;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    logic mark_hit;
    logic scan_end;
    logic gap;
    logic div_done;
    logic fill_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> sv/crlm_ctrl.sv
`default_nettype none
module crlm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        in_command_i,
  input  crlm_pkg::status_t status_i,
  output crlm_pkg::ctrl_t   ctrl_o
);
  import crlm_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOOK  = 7'b0000010,
    ST_KEYW  = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_RDKEY = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_FILL  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  cmd_e   cmd;

  assign cmd        = cmd_e'(in_command_i);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd)
            CMD_RESET: ctrl_o.tbl_reset = 1'b1;
            CMD_SET_KEY: begin
              ctrl_o.rd_en    = 1'b1;
              ctrl_o.rd_sel   = RA_KEY;
              ctrl_o.key_load = 1'b1;
              state_d         = ST_KEYW;
            end
            CMD_BUILD: begin
              ctrl_o.scan_clear = 1'b1;
              state_d           = ST_SCAN;
            end
            CMD_PIXEL: begin
              ctrl_o.rd_en    = 1'b1;
              ctrl_o.rd_sel   = RA_PIXEL;
              ctrl_o.pix_load = 1'b1;
              state_d         = ST_LOOK;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOK: begin
        if (status_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_KEYW: begin
        ctrl_o.key_write = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_SCAN: begin
        if (status_i.scan_end) begin
          state_d = ST_IDLE;
        end else if (status_i.mark_hit) begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = RA_SCAN;
          state_d       = ST_RDKEY;
        end else begin
          ctrl_o.scan_inc = 1'b1;
        end
      end
      ST_RDKEY: begin
        ctrl_o.hi_load = 1'b1;
        if (status_i.gap) begin
          state_d = ST_DIV;
        end else begin
          ctrl_o.prev_load = 1'b1;
          ctrl_o.scan_inc  = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (status_i.div_done) state_d = ST_FILL;
      end
      ST_FILL: begin
        ctrl_o.fill_step = 1'b1;
        if (status_i.fill_last) begin
          ctrl_o.prev_load    = 1'b1;
          ctrl_o.prev_from_hi = 1'b1;
          ctrl_o.scan_inc     = 1'b1;
          state_d             = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |-> $past(ctrl_o.pix_load) || $past(state_q == ST_LOOK))
    else $error("result loaded without a lookup");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> $past(state_q == ST_DIV) || $past(state_q == ST_FILL))
    else $error("fill entered without division");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KEYW) |=> (state_q == ST_IDLE))
    else $error("key write not single cycle");

endmodule
`default_nettype wire

>>> sv/crlm_dp.sv
`default_nettype none
module crlm_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  crlm_pkg::ctrl_t           ctrl_i,
  output crlm_pkg::status_t         status_o,
  input  logic                      cfg_we_i,
  input  logic [crlm_pkg::CfgW-1:0] cfg_data_i,
  input  logic [7:0]                key_index_i,
  input  logic [1:0]                key_channels_i,
  input  logic [7:0]                key_red_i,
  input  logic [7:0]                key_green_i,
  input  logic [7:0]                key_blue_i,
  input  logic [7:0]                pixel_value_i,
  input  logic                      pixel_valid_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                out_red_o,
  output logic [7:0]                out_green_o,
  output logic [7:0]                out_blue_o,
  output logic [7:0]                out_alpha_o
);
  import crlm_pkg::*;

  logic [EntryW-1:0]     mem [NumEntries];
  logic [NumEntries-1:0] valid_q;
  logic [NumEntries-1:0] marks_q;
  logic [EntryW-1:0]     rd_data_q;
  logic                  rd_ok_q;
  logic [IdxW-1:0]       rd_addr_q;
  logic [IdxW-1:0]       rd_addr;
  logic [EntryW-1:0]     tbl_val;

  logic                  we;
  logic [IdxW-1:0]       wa;
  logic [EntryW-1:0]     wd;

  logic [CfgW-1:0]       cfg_q;
  logic [IdxW-1:0]       key_idx_q;
  logic [1:0]            key_nch_q;
  logic [ChanW-1:0]      key_r_q, key_g_q, key_b_q;
  logic                  pix_ok_q;
  logic [EntryW-1:0]     merged;

  logic [IdxW:0]         i_q;
  logic [IdxW-1:0]       a_q;
  logic                  have_prev_q;
  logic [IdxW-1:0]       n;
  logic [IdxW-1:0]       j_q;
  logic [EntryW-1:0]     lo_q, hi_q;
  logic [2:0]            div_cnt_q;

  logic [ChanW-1:0] dvd_q [NumChan];
  logic [ChanW-1:0] rem_q [NumChan];
  logic [ChanW-1:0] quo_q [NumChan];
  logic             neg_q [NumChan];
  logic [ChanW-1:0] q_q   [NumChan];
  logic [ChanW-1:0] r_q   [NumChan];

  logic [ChanW-1:0] lo_b [NumChan];
  logic [ChanW-1:0] hi_b [NumChan];
  logic             neg_d  [NumChan];
  logic [ChanW-1:0] mag_d  [NumChan];
  logic [ChanW:0]   rem_t  [NumChan];
  logic             ge     [NumChan];
  logic [ChanW-1:0] rem_d  [NumChan];
  logic [ChanW-1:0] qd     [NumChan];
  logic [ChanW-1:0] rd     [NumChan];
  logic [ChanW:0]   r9     [NumChan];
  logic             carry  [NumChan];
  logic [ChanW-1:0] rnew   [NumChan];
  logic [ChanW-1:0] qnew   [NumChan];
  logic [EntryW-1:0] fill_word;

  logic             out_valid_q;
  logic [EntryW-1:0] out_q;

  // table read port
  always_comb begin
    case (ctrl_i.rd_sel)
      RA_PIXEL: rd_addr = pixel_value_i;
      RA_KEY:   rd_addr = key_index_i;
      RA_SCAN:  rd_addr = i_q[IdxW-1:0];
      default:  rd_addr = i_q[IdxW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
    end else if (ctrl_i.rd_en) begin
      rd_ok_q <= valid_q[rd_addr];
    end
  end

  assign tbl_val = rd_ok_q ? rd_data_q :
                   ((rd_addr_q == '0) ? EntryBlack : EntryWhite);

  always_comb begin
    merged = tbl_val;
    if (key_nch_q != 2'd0) merged[31:24] = key_r_q;
    if (key_nch_q[1])      merged[23:16] = key_g_q;
    if (key_nch_q == 2'd3) merged[15:8]  = key_b_q;
  end

  assign we = ctrl_i.key_write | ctrl_i.fill_step;
  assign wa = ctrl_i.key_write ? key_idx_q : j_q;
  assign wd = ctrl_i.key_write ? merged : fill_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      marks_q <= NumEntries'(1) | (NumEntries'(1) << (NumEntries - 1));
    end else if (ctrl_i.tbl_reset) begin
      valid_q <= '0;
      marks_q <= NumEntries'(1) | (NumEntries'(1) << (NumEntries - 1));
    end else begin
      if (we) valid_q[wa] <= 1'b1;
      if (ctrl_i.key_write && key_nch_q != 2'd0) marks_q[key_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ChanRgba;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.key_load) begin
      key_idx_q <= key_index_i;
      key_nch_q <= key_channels_i;
      key_r_q   <= key_red_i;
      key_g_q   <= key_green_i;
      key_b_q   <= key_blue_i;
    end
    if (ctrl_i.pix_load) pix_ok_q <= pixel_valid_i;
  end

  // ramp scan
  assign n = i_q[IdxW-1:0] - a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      have_prev_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      if (ctrl_i.scan_clear) begin
        i_q         <= '0;
        have_prev_q <= 1'b0;
      end else begin
        if (ctrl_i.scan_inc)  i_q <= i_q + 1'b1;
        if (ctrl_i.prev_load) have_prev_q <= 1'b1;
      end
      if (ctrl_i.hi_load)       div_cnt_q <= '0;
      else if (ctrl_i.div_step) div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prev_load) begin
      a_q  <= i_q[IdxW-1:0];
      lo_q <= ctrl_i.prev_from_hi ? hi_q : tbl_val;
    end
    if (ctrl_i.hi_load) begin
      hi_q <= tbl_val;
      j_q  <= a_q + 1'b1;
    end else if (ctrl_i.fill_step) begin
      j_q  <= j_q + 1'b1;
    end
  end

  always_comb begin
    for (int l = 0; l < NumChan; l++) begin
      lo_b[l]  = lo_q[EntryW-1-l*ChanW -: ChanW];
      hi_b[l]  = tbl_val[EntryW-1-l*ChanW -: ChanW];
      neg_d[l] = hi_b[l] < lo_b[l];
      mag_d[l] = neg_d[l] ? (lo_b[l] - hi_b[l]) : (hi_b[l] - lo_b[l]);
      rem_t[l] = {rem_q[l], dvd_q[l][ChanW-1]};
      ge[l]    = rem_t[l] >= {1'b0, n};
      rem_d[l] = ge[l] ? 8'(rem_t[l] - {1'b0, n}) : rem_t[l][ChanW-1:0];
      if (!neg_q[l]) begin
        qd[l] = quo_q[l];
        rd[l] = rem_q[l];
      end else if (rem_q[l] == '0) begin
        qd[l] = 8'(0) - quo_q[l];
        rd[l] = '0;
      end else begin
        qd[l] = 8'(0) - quo_q[l] - 8'd1;
        rd[l] = n - rem_q[l];
      end
      r9[l]    = {1'b0, r_q[l]} + {1'b0, rd[l]};
      carry[l] = r9[l] >= {1'b0, n};
      rnew[l]  = carry[l] ? 8'(r9[l] - {1'b0, n}) : r9[l][ChanW-1:0];
      qnew[l]  = q_q[l] + qd[l] + {7'd0, carry[l]};
      fill_word[EntryW-1-l*ChanW -: ChanW] = lo_b[l] + qnew[l];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NumChan; l++) begin
      if (ctrl_i.hi_load) begin
        dvd_q[l] <= mag_d[l];
        neg_q[l] <= neg_d[l];
        rem_q[l] <= '0;
        quo_q[l] <= '0;
        q_q[l]   <= '0;
        r_q[l]   <= '0;
      end else if (ctrl_i.div_step) begin
        dvd_q[l] <= {dvd_q[l][ChanW-2:0], 1'b0};
        rem_q[l] <= rem_d[l];
        quo_q[l] <= {quo_q[l][ChanW-2:0], ge[l]};
      end else if (ctrl_i.fill_step) begin
        q_q[l] <= qnew[l];
        r_q[l] <= rnew[l];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      if (!pix_ok_q) begin
        out_q <= EntryMask;
      end else begin
        out_q <= {tbl_val[EntryW-1:ChanW], (cfg_q == ChanRgba) ? tbl_val[ChanW-1:0] : 8'd0};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q[31:24];
  assign out_green_o = out_q[23:16];
  assign out_blue_o  = out_q[15:8];
  assign out_alpha_o = out_q[7:0];

  assign status_o.mark_hit  = marks_q[i_q[IdxW-1:0]];
  assign status_o.scan_end  = i_q[IdxW];
  assign status_o.gap       = have_prev_q && (n > 8'd1);
  assign status_o.div_done  = (div_cnt_q == 3'd7);
  assign status_o.fill_last = (j_q == i_q[IdxW-1:0] - 1'b1);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fill_step |-> (j_q > a_q) && (j_q < i_q[IdxW-1:0]))
    else $error("fill index outside gap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fill_step |-> (r_q[0] < n) && (rd[0] < n))
    else $error("interpolation remainder out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.div_step |-> have_prev_q && (n > 8'd1))
    else $error("division without a gap");

endmodule
`default_nettype wire

>>> sv/color_ramp_lut_mapper_core.sv
`default_nettype none
// channel | dir | handshake             | payload
// in      | in  | in_valid_i/in_stall_o | command, key fields, pixel fields
// out     | out | out_valid_o/out_stall_i | out_red/green/blue/alpha
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_data_i (output_channels)
// One word at a time. Reset word: clears the table. Set key and pixel:
// registered table read, then write or result load.
// Build: scans every entry (256); each marked entry gets a table read, and
// per gap the divider runs, then each entry in the gap is filled.
// rst_ni clears the table to white with black entry 0 through per-entry
// valid bits; no clearing pass. A stalled result holds and the next word
// is still taken; a pixel waits in lookup until the output register frees.
module color_ramp_lut_mapper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] in_command_i,
  input  logic [7:0] in_key_index_i,
  input  logic [1:0] in_key_channels_i,
  input  logic [7:0] in_key_red_i,
  input  logic [7:0] in_key_green_i,
  input  logic [7:0] in_key_blue_i,
  input  logic [7:0] in_pixel_value_i,
  input  logic       in_pixel_valid_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o
);
  import crlm_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  assign cfg_ready_o = 1'b1;

  crlm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_command_i (in_command_i),
    .status_i     (status),
    .ctrl_o       (ctrl)
  );

  crlm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .key_index_i    (in_key_index_i),
    .key_channels_i (in_key_channels_i),
    .key_red_i      (in_key_red_i),
    .key_green_i    (in_key_green_i),
    .key_blue_i     (in_key_blue_i),
    .pixel_value_i  (in_pixel_value_i),
    .pixel_valid_i  (in_pixel_valid_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .out_alpha_o    (out_alpha_o)
  );

endmodule
`default_nettype wire
